### design/bgb_pkg.sv
// Shared types, codes and constants for the bitmap glyph blitter.
// Used by bgb_metric_mem and bitmap_glyph_blitter_unit; no dependencies.

package bgb_pkg;

    // default sizes of the glyph stores
    localparam int GLYPH_COUNT_DEF       = 128;
    localparam int PIXEL_STORE_DEPTH_DEF = 4096;
    localparam int MAX_GLYPH_DIM_DEF     = 8;

    // writes per draw are capped
    localparam int MAX_OUT = 64;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd800;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd150;
    localparam logic [7:0]  TRANSPARENT_RST  = 8'd0;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TRANSPARENT  = 2'd2;

    localparam logic [2:0] KIND_LOAD_METRICS = 3'd0;
    localparam logic [2:0] KIND_LOAD_PIXEL   = 3'd1;
    localparam logic [2:0] KIND_MEASURE      = 3'd2;
    localparam logic [2:0] KIND_PLACE        = 3'd3;
    localparam logic [2:0] KIND_DRAW         = 3'd4;

    localparam logic [1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [1:0] ALIGN_CENTRE = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

    typedef struct packed {
        logic [3:0]        w;
        logic [3:0]        h;
        logic [11:0]       start;
        logic signed [5:0] left;
        logic signed [5:0] top;
        logic [5:0]        adv;
    } glyph_metrics_t;

    // clamp to the 13-bit signed pen range
    function automatic logic signed [12:0] sat13(input logic signed [16:0] v);
        logic signed [12:0] r;
        if (v > 17'sd4095)
        begin
            r = 13'sd4095;
        end
        else if (v < -17'sd4096)
        begin
            r = -13'sd4096;
        end
        else
        begin
            r = v[12:0];
        end
        return r;
    endfunction

endpackage

### design/bgb_metric_mem.sv
// Glyph metrics store: one write port, one registered read port.
// Depends on bgb_pkg for the metrics record type.

module bgb_metric_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  bgb_pkg::glyph_metrics_t wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output bgb_pkg::glyph_metrics_t rdata
);

    bgb_pkg::glyph_metrics_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/bgb_pixel_mem.sv
// Glyph pixel store: 8-bit grey values, one write port, one registered read.
// No package dependencies.

module bgb_pixel_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/bitmap_glyph_blitter_unit.sv
// Bitmap glyph blitter top level: sequencer, pen state and pixel walker.
// Depends on bgb_pkg, bgb_metric_mem and bgb_pixel_mem.
//
//   channel   signals                         beat carries
//   cfg       cfg_write_en/index/data         one register write, no wait
//   in        in_valid/in_ready               one load, measure, place or draw
//   out       out_valid/out_ready             one framebuffer write or end mark
//
// Load and place finish in idle, measure via ST_MEAS. A draw runs ST_MET, ST_MUL,
// ST_RED (repeated per pixel-store wrap of the start offset), ST_WALK and ST_END;
// empty glyphs skip ST_RED/ST_WALK, out-of-range codes go straight to ST_END. The
// walk reads one glyph pixel per cycle from the pixel store, unless output stalls.
// in_ready is high only while idle; the output register lets the last beat wait.
// Async active-low reset clears control, pen and width accumulator.

module bitmap_glyph_blitter_unit #(
    parameter int GLYPH_COUNT       = bgb_pkg::GLYPH_COUNT_DEF,
    parameter int PIXEL_STORE_DEPTH = bgb_pkg::PIXEL_STORE_DEPTH_DEF,
    parameter int MAX_GLYPH_DIM     = bgb_pkg::MAX_GLYPH_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [6:0]         char_code,
    input  logic [3:0]         glyph_width,
    input  logic [3:0]         glyph_height,
    input  logic [11:0]        pixel_index,
    input  logic signed [5:0]  offset_left,
    input  logic signed [5:0]  offset_top,
    input  logic [5:0]         advance,
    input  logic [7:0]         pixel_value,
    input  logic [1:0]         align,
    input  logic signed [12:0] pen_x,
    input  logic signed [12:0] pen_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_pixel,
    output logic [21:0]        frame_address,
    output logic [7:0]         color,
    output logic               last_write
);

    import bgb_pkg::*;

    localparam int GA = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int PA = $clog2(PIXEL_STORE_DEPTH);
    localparam int AW = (PA >= 12) ? PA : 12;
    localparam logic [8:0]  GCOUNT  = 9'(GLYPH_COUNT);
    localparam logic [16:0] PDEPTH  = 17'(PIXEL_STORE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(PIXEL_STORE_DEPTH);
    localparam logic [6:0]  MAXD    = 7'(MAX_GLYPH_DIM);
    localparam logic [6:0]  MAXO    = 7'(MAX_OUT);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MEAS = 7'b0000010,
        ST_MET  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_RED  = 7'b0010000,
        ST_WALK = 7'b0100000,
        ST_END  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] fw_reg, fh_reg;
    logic [7:0]  tv_reg;

    logic signed [12:0] pen_x_reg, pen_x_next;
    logic signed [12:0] pen_y_reg, pen_y_next;
    logic [15:0]        acc_reg, acc_next;

    logic               draw_ok_reg, draw_ok_next;
    logic [3:0]         gw_reg, gw_next, gh_reg, gh_next;
    logic [5:0]         adv_reg, adv_next;
    logic [3:0]         col_reg, col_next, row_reg, row_next;
    logic signed [14:0] fx_base_reg, fx_base_next;
    logic signed [14:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [21:0]        row_base_reg, row_base_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next, rd_addr_inc;
    logic [6:0]         n_reg, n_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [21:0] pend_addr_reg, pend_addr_next;
    logic [7:0]  pend_color_reg, pend_color_next;

    logic        out_valid_reg;
    logic        wp_reg, last_reg;
    logic [21:0] addr_reg;
    logic [7:0]  color_reg;

    logic        push, push_wp, push_last;
    logic [21:0] push_addr;
    logic [7:0]  push_color;
    logic        out_free;

    logic           accept, glyph_ok, idx_ok;
    logic           mm_we, mm_re, pm_we, pm_re;
    glyph_metrics_t mm_wdata, mm_q;
    logic [7:0]     pm_q;
    logic [3:0]     w_sat, h_sat;

    logic signed [16:0] place_x;
    logic signed [27:0] prod;
    logic [16:0]        acc_sum;
    logic               in_frame, hit, last_px;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign glyph_ok = ({2'b0, char_code} < GCOUNT);
    assign idx_ok   = ({5'b0, pixel_index} < PDEPTH);
    assign out_free = !out_valid_reg || out_ready;

    assign w_sat = ({3'b0, glyph_width}  > MAXD) ? MAXD[3:0] : glyph_width;
    assign h_sat = ({3'b0, glyph_height} > MAXD) ? MAXD[3:0] : glyph_height;

    always_comb
    begin
        mm_wdata.w     = w_sat;
        mm_wdata.h     = h_sat;
        mm_wdata.start = pixel_index;
        mm_wdata.left  = offset_left;
        mm_wdata.top   = offset_top;
        mm_wdata.adv   = advance;
    end

    assign mm_we = accept && (kind == KIND_LOAD_METRICS) && glyph_ok;
    assign pm_we = accept && (kind == KIND_LOAD_PIXEL) && idx_ok;

    bgb_metric_mem #(
        .DEPTH (GLYPH_COUNT),
        .AW    (GA)
    ) u_metric_mem (
        .clk   (clk),
        .we    (mm_we),
        .waddr (GA'(char_code)),
        .wdata (mm_wdata),
        .re    (mm_re),
        .raddr (GA'(char_code)),
        .rdata (mm_q)
    );

    bgb_pixel_mem #(
        .DEPTH (PIXEL_STORE_DEPTH),
        .AW    (PA)
    ) u_pixel_mem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (PA'(pixel_index)),
        .wdata (pixel_value),
        .re    (pm_re),
        .raddr (rd_addr_reg[PA-1:0]),
        .rdata (pm_q)
    );

    always_comb
    begin
        case (align)
            ALIGN_CENTRE: place_x = $signed({6'b0, fw_reg[11:1]}) - $signed({2'b0, acc_reg[15:1]});
            ALIGN_RIGHT:  place_x = $signed({5'b0, fw_reg}) - $signed({1'b0, acc_reg});
            default:      place_x = 17'(pen_x);
        endcase
    end

    assign prod    = fy_reg * $signed({1'b0, fw_reg});
    assign acc_sum = {1'b0, acc_reg} + {11'b0, mm_q.adv};

    assign rd_addr_inc = ({1'b0, rd_addr_reg} == DEPTH_W - 1'b1) ? '0 : rd_addr_reg + 1'b1;

    assign in_frame = !fx_reg[14] && (fx_reg[13:0] < {2'b0, fw_reg})
                   && !fy_reg[14] && (fy_reg[13:0] < {2'b0, fh_reg});
    assign hit      = (pm_q != tv_reg) && in_frame && (n_reg < MAXO);
    assign last_px  = (col_reg == gw_reg - 4'd1) && (row_reg == gh_reg - 4'd1);

    always_comb
    begin
        state_next      = state_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        acc_next        = acc_reg;
        draw_ok_next    = draw_ok_reg;
        gw_next         = gw_reg;
        gh_next         = gh_reg;
        adv_next        = adv_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fx_base_next    = fx_base_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        row_base_next   = row_base_reg;
        rd_addr_next    = rd_addr_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_color_next = pend_color_reg;
        mm_re           = 1'b0;
        pm_re           = 1'b0;
        push            = 1'b0;
        push_wp         = 1'b0;
        push_addr       = '0;
        push_color      = '0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        KIND_MEASURE:
                        begin
                            if (glyph_ok)
                            begin
                                mm_re      = 1'b1;
                                state_next = ST_MEAS;
                            end
                        end
                        KIND_PLACE:
                        begin
                            pen_x_next = sat13(place_x);
                            pen_y_next = pen_y;
                            acc_next   = '0;
                        end
                        KIND_DRAW:
                        begin
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            draw_ok_next    = glyph_ok;
                            if (glyph_ok)
                            begin
                                mm_re      = 1'b1;
                                state_next = ST_MET;
                            end
                            else
                            begin
                                state_next = ST_END;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MEAS:
            begin
                acc_next   = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
                state_next = ST_IDLE;
            end
            ST_MET:
            begin
                gw_next      = mm_q.w;
                gh_next      = mm_q.h;
                adv_next     = mm_q.adv;
                fx_base_next = 15'(pen_x_reg) + 15'(mm_q.left);
                fx_next      = 15'(pen_x_reg) + 15'(mm_q.left);
                fy_next      = 15'(pen_y_reg) + 15'(mm_q.top);
                rd_addr_next = AW'(mm_q.start);
                col_next     = '0;
                row_next     = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                row_base_next = prod[21:0];
                if ((gw_reg == 4'd0) || (gh_reg == 4'd0))
                begin
                    state_next = ST_END;
                end
                else
                begin
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                // bring the start offset into the store range
                if ({1'b0, rd_addr_reg} >= DEPTH_W)
                begin
                    rd_addr_next = rd_addr_reg - DEPTH_W[AW-1:0];
                end
                else
                begin
                    pm_re        = 1'b1;
                    rd_addr_next = rd_addr_inc;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_addr_next  = row_base_reg + {10'b0, fx_reg[11:0]};
                        pend_color_next = pm_q;
                        n_next          = n_reg + 7'd1;
                        if (pend_valid_reg)
                        begin
                            push       = 1'b1;
                            push_wp    = 1'b1;
                            push_addr  = pend_addr_reg;
                            push_color = pend_color_reg;
                        end
                    end
                    if (last_px)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        pm_re        = 1'b1;
                        rd_addr_next = rd_addr_inc;
                        if (col_reg == gw_reg - 4'd1)
                        begin
                            col_next      = '0;
                            row_next      = row_reg + 4'd1;
                            fx_next       = fx_base_reg;
                            fy_next       = fy_reg + 15'sd1;
                            row_base_next = row_base_reg + {10'b0, fw_reg};
                        end
                        else
                        begin
                            col_next = col_reg + 4'd1;
                            fx_next  = fx_reg + 15'sd1;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_wp         = pend_valid_reg;
                    push_addr       = pend_valid_reg ? pend_addr_reg : '0;
                    push_color      = pend_valid_reg ? pend_color_reg : '0;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (draw_ok_reg)
                    begin
                        pen_x_next = sat13(17'(pen_x_reg) + {11'b0, adv_reg});
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fw_reg         <= FRAME_WIDTH_RST;
            fh_reg         <= FRAME_HEIGHT_RST;
            tv_reg         <= TRANSPARENT_RST;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            acc_reg        <= '0;
            draw_ok_reg    <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            acc_reg        <= acc_next;
            draw_ok_reg    <= draw_ok_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    CFG_TRANSPARENT:  tv_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gw_reg         <= gw_next;
        gh_reg         <= gh_next;
        adv_reg        <= adv_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        fx_base_reg    <= fx_base_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        row_base_reg   <= row_base_next;
        rd_addr_reg    <= rd_addr_next;
        pend_addr_reg  <= pend_addr_next;
        pend_color_reg <= pend_color_next;
        if (push)
        begin
            wp_reg    <= push_wp;
            addr_reg  <= push_addr;
            color_reg <= push_color;
            last_reg  <= push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_pixel   = wp_reg;
    assign frame_address = addr_reg;
    assign color         = color_reg;
    assign last_write    = last_reg;

endmodule
